### src/ltrm_pkg.sv
`timescale 1ns / 1ps

package ltrm_pkg;

    // beat formats on the ports
    typedef struct packed {
        logic [13:0] civil_year;
        logic [3:0]  civil_month;
        logic [4:0]  civil_day;
        logic [4:0]  local_hour;
        logic [5:0]  wall_minute;
        logic        repeat_in_summer;
    } in_beat_t;

    typedef struct packed {
        logic signed [32:0] reference_minutes;
        logic               summer_time;
    } out_beat_t;

    // month classes for the daylight saving decision
    localparam logic [1:0] MCLASS_WINTER  = 2'd0;
    localparam logic [1:0] MCLASS_SUMMER  = 2'd1;
    localparam logic [1:0] MCLASS_MARCH   = 2'd2;
    localparam logic [1:0] MCLASS_OCTOBER = 2'd3;

    // one 400-year era added so the year never goes negative
    localparam logic [14:0] YEAR_BIAS     = 15'd400;
    localparam logic [22:0] DAYS_PER_YEAR = 23'd365;
    // x / 25 as (x * 5243) >> 17, exact for x below 2^13
    localparam logic [12:0] DIV25_MUL     = 13'd5243;
    localparam int          DIV25_SHIFT   = 17;
    localparam int          Q25_W         = 8;
    // x / 7 as (x * 37450) >> 18, exact for x below 2^15
    localparam logic [15:0] DIV7_MUL      = 16'd37450;
    localparam int          DIV7_SHIFT    = 18;
    localparam int          Q7_W          = 12;
    // weekday of march 31 is (wk_sum + 5) mod 7, sunday = 0
    localparam logic [14:0] WDAY_BIAS     = 15'd5;
    localparam logic [33:0] MIN_PER_DAY   = 34'd1440;
    localparam logic [10:0] MIN_PER_HOUR  = 11'd60;
    // biased day count of 1970-01-01 times minutes per day
    localparam logic [32:0] EPOCH_MINUTES = 33'd1246415040;
    localparam logic [32:0] STD_OFFSET    = 33'd60;
    localparam logic [4:0]  MONTH_END_DAY = 5'd31;

    // day count stage output
    typedef struct packed {
        logic [22:0] day_sum;
        logic [14:0] wk_sum;
        logic [1:0]  mclass;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic        rep;
    } dc_beat_t;

    // scale stage output
    typedef struct packed {
        logic [32:0]     base;
        logic [10:0]     hm;
        logic [14:0]     wk_sum;
        logic [Q7_W-1:0] wk_q;
        logic [1:0]      mclass;
        logic [4:0]      day;
        logic [4:0]      hour;
        logic            rep;
    } sc_beat_t;

    // (153 * shifted_month + 2) / 5, march based, linear past december
    function automatic logic [8:0] doy_base(input logic [3:0] month);
        logic [8:0] r;
        unique case (month)
            4'd0:    r = 9'd275;
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd13:   r = 9'd306;
            4'd14:   r = 9'd337;
            default: r = 9'd367;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] month_class(input logic [3:0] month);
        logic [1:0] r;
        if (month > 4'd3 && month < 4'd10) begin
            r = MCLASS_SUMMER;
        end else if (month == 4'd3) begin
            r = MCLASS_MARCH;
        end else if (month == 4'd10) begin
            r = MCLASS_OCTOBER;
        end else begin
            r = MCLASS_WINTER;
        end
        return r;
    endfunction

endpackage

### src/ltrm_day_count.sv
`timescale 1ns / 1ps

module ltrm_day_count (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ltrm_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output ltrm_pkg::dc_beat_t  out_beat
);

    typedef struct packed {
        logic [14:0]                yy;
        logic [14:0]                ym;
        logic [ltrm_pkg::Q25_W-1:0] qa;
        logic [ltrm_pkg::Q25_W-1:0] qb;
        logic [ltrm_pkg::Q25_W-1:0] qam;
        logic [ltrm_pkg::Q25_W-1:0] qbm;
        logic [8:0]                 doyd;
        logic [1:0]                 mclass;
        logic [4:0]                 day;
        logic [4:0]                 hour;
        logic [5:0]                 minute;
        logic                       rep;
    } p1_t;

    logic               s1_valid_reg;
    p1_t                s1_reg;
    p1_t                s1_next;
    logic               s1_ready;
    logic               s2_valid_reg;
    ltrm_pkg::dc_beat_t s2_reg;
    ltrm_pkg::dc_beat_t s2_next;
    logic               s2_ready;

    logic [14:0] yy_c;
    logic [14:0] ym_c;
    logic [25:0] prod_a;
    logic [25:0] prod_b;
    logic [25:0] prod_am;
    logic [25:0] prod_bm;

    // stage 1: biased years and the /25 products
    always_comb begin
        yy_c = 15'(in_beat.civil_year) + ltrm_pkg::YEAR_BIAS
             - ((in_beat.civil_month <= 4'd2) ? 15'd1 : 15'd0);
        ym_c = 15'(in_beat.civil_year) + ltrm_pkg::YEAR_BIAS;
        prod_a  = 26'(yy_c[14:2]) * 26'(ltrm_pkg::DIV25_MUL);
        prod_b  = 26'(yy_c[14:4]) * 26'(ltrm_pkg::DIV25_MUL);
        prod_am = 26'(ym_c[14:2]) * 26'(ltrm_pkg::DIV25_MUL);
        prod_bm = 26'(ym_c[14:4]) * 26'(ltrm_pkg::DIV25_MUL);
        s1_next.yy     = yy_c;
        s1_next.ym     = ym_c;
        s1_next.qa     = prod_a[ltrm_pkg::DIV25_SHIFT +: ltrm_pkg::Q25_W];
        s1_next.qb     = prod_b[ltrm_pkg::DIV25_SHIFT +: ltrm_pkg::Q25_W];
        s1_next.qam    = prod_am[ltrm_pkg::DIV25_SHIFT +: ltrm_pkg::Q25_W];
        s1_next.qbm    = prod_bm[ltrm_pkg::DIV25_SHIFT +: ltrm_pkg::Q25_W];
        s1_next.doyd   = ltrm_pkg::doy_base(in_beat.civil_month) + 9'(in_beat.civil_day);
        s1_next.mclass = ltrm_pkg::month_class(in_beat.civil_month);
        s1_next.day    = in_beat.civil_day;
        s1_next.hour   = in_beat.local_hour;
        s1_next.minute = in_beat.wall_minute;
        s1_next.rep    = in_beat.repeat_in_summer;
    end

    // stage 2: biased day count and weekday sum
    always_comb begin
        s2_next.day_sum = 23'(s1_reg.yy) * ltrm_pkg::DAYS_PER_YEAR
                        + 23'(s1_reg.yy[14:2]) - 23'(s1_reg.qa) + 23'(s1_reg.qb)
                        + 23'(s1_reg.doyd);
        s2_next.wk_sum  = s1_reg.ym + 15'(s1_reg.ym[14:2]) - 15'(s1_reg.qam)
                        + 15'(s1_reg.qbm) + ltrm_pkg::WDAY_BIAS;
        s2_next.mclass  = s1_reg.mclass;
        s2_next.day     = s1_reg.day;
        s2_next.hour    = s1_reg.hour;
        s2_next.minute  = s1_reg.minute;
        s2_next.rep     = s1_reg.rep;
    end

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_beat  = s2_reg;

endmodule

### src/ltrm_scale.sv
`timescale 1ns / 1ps

module ltrm_scale (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ltrm_pkg::dc_beat_t in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output ltrm_pkg::sc_beat_t out_beat
);

    logic               valid_reg;
    ltrm_pkg::sc_beat_t beat_reg;
    ltrm_pkg::sc_beat_t beat_next;
    logic [33:0]        base_prod;
    logic [30:0]        wk_prod;

    // days to minutes, and weekday quotient by 7
    always_comb begin
        base_prod = 34'(in_beat.day_sum) * ltrm_pkg::MIN_PER_DAY;
        wk_prod   = 31'(in_beat.wk_sum) * 31'(ltrm_pkg::DIV7_MUL);
        beat_next.base   = base_prod[32:0];
        beat_next.hm     = 11'(in_beat.hour) * ltrm_pkg::MIN_PER_HOUR
                         + 11'(in_beat.minute);
        beat_next.wk_sum = in_beat.wk_sum;
        beat_next.wk_q   = wk_prod[ltrm_pkg::DIV7_SHIFT +: ltrm_pkg::Q7_W];
        beat_next.mclass = in_beat.mclass;
        beat_next.day    = in_beat.day;
        beat_next.hour   = in_beat.hour;
        beat_next.rep    = in_beat.rep;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

### src/ltrm_judge.sv
`timescale 1ns / 1ps

module ltrm_judge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ltrm_pkg::sc_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output ltrm_pkg::out_beat_t out_beat
);

    localparam logic [4:0] START_HOUR = 5'd2;
    localparam logic [4:0] END_HOUR   = 5'd3;

    logic                valid_reg;
    ltrm_pkg::out_beat_t beat_reg;
    ltrm_pkg::out_beat_t beat_next;
    logic [14:0]         wd_full;
    logic [2:0]          wd_mar;
    logic [2:0]          wd_oct;
    logic [4:0]          mar_sun;
    logic [4:0]          oct_sun;
    logic                dst;
    logic [32:0]         total;

    always_comb begin
        // remainder by 7: sum - 8q + q
        wd_full = in_beat.wk_sum - {in_beat.wk_q, 3'b000} + 15'(in_beat.wk_q);
        wd_mar  = wd_full[2:0];
        // october 31 falls 214 days later, four weekdays on
        wd_oct  = (wd_mar >= 3'd3) ? wd_mar - 3'd3 : wd_mar + 3'd4;
        mar_sun = ltrm_pkg::MONTH_END_DAY - 5'(wd_mar);
        oct_sun = ltrm_pkg::MONTH_END_DAY - 5'(wd_oct);
        unique case (in_beat.mclass)
            ltrm_pkg::MCLASS_SUMMER: begin
                dst = 1'b1;
            end
            ltrm_pkg::MCLASS_MARCH: begin
                dst = (in_beat.day > mar_sun)
                   || (in_beat.day == mar_sun && in_beat.hour >= START_HOUR);
            end
            ltrm_pkg::MCLASS_OCTOBER: begin
                if (in_beat.day == oct_sun && in_beat.hour == START_HOUR) begin
                    dst = in_beat.rep;
                end else begin
                    dst = (in_beat.day < oct_sun)
                       || (in_beat.day == oct_sun && in_beat.hour < END_HOUR);
                end
            end
            default: begin
                dst = 1'b0;
            end
        endcase
        total = in_beat.base + 33'(in_beat.hm)
              + (dst ? 33'd0 : ltrm_pkg::STD_OFFSET) - ltrm_pkg::EPOCH_MINUTES;
        beat_next.reference_minutes = $signed(total);
        beat_next.summer_time       = dst;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

### src/local_time_to_reference_minutes_core.sv
`timescale 1ns / 1ps

// channel   ports                          beat
// input     s_valid s_ready s_payload      local timestamp (in_beat_t)
// result    m_valid m_ready m_payload      reference minutes, dst flag (out_beat_t)
//
// one beat per cycle sustained while m_ready stays high
// four register stages: /25 products, day sums, the 1440x and /7 multiplies, output
// reset is synchronous and clears only the stage valid bits
// ready ripples back from m_ready; a full stage holds while its successor is stalled

module local_time_to_reference_minutes_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ltrm_pkg::in_beat_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output ltrm_pkg::out_beat_t m_payload
);

    // day count to scale
    logic               dc_valid;
    logic               dc_ready;
    ltrm_pkg::dc_beat_t dc_beat;

    // scale to judge
    logic               sc_valid;
    logic               sc_ready;
    ltrm_pkg::sc_beat_t sc_beat;

    // stages 1-2: biased days since era start, weekday sum of march 31
    ltrm_day_count u_day_count (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_beat   (s_payload),
        .out_valid (dc_valid),
        .out_ready (dc_ready),
        .out_beat  (dc_beat)
    );

    // stage 3: days to minutes, weekday quotient
    ltrm_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dc_valid),
        .in_ready  (dc_ready),
        .in_beat   (dc_beat),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_beat  (sc_beat)
    );

    // stage 4: last sundays, dst decision, final sum into the output register
    ltrm_judge u_judge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sc_valid),
        .in_ready  (sc_ready),
        .in_beat   (sc_beat),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_beat  (m_payload)
    );

endmodule

### src/ltrm_checker.sv
`timescale 1ns / 1ps

module ltrm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ltrm_pkg::out_beat_t m_payload
);

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result beat changed while stalled");

    // reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an open result side never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while result side ready");

    // with the result side held open after acceptance, an accepted beat reaches the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("result beat missing after pipeline latency");

endmodule

bind local_time_to_reference_minutes_core ltrm_checker u_ltrm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
